@@ design/rpc_pkg.sv @@
package rpc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned TDATA_W = 8;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// Register index in the configuration map
	localparam logic [PADDR_W-3:0] REG_EXTENDED_SYNTAX = 1'b0;

	localparam logic [BYTE_W-1:0] CH_CARET     = 8'h5E;
	localparam logic [BYTE_W-1:0] CH_DOLLAR    = 8'h24;
	localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_ONE       = 8'h31;
	localparam logic [BYTE_W-1:0] CH_NINE      = 8'h39;
	localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_DOT       = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_QUESTION  = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_PIPE      = 8'h7C;
	localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
	localparam logic [BYTE_W-1:0] CH_RPAREN    = 8'h29;

	typedef enum logic [2:0] {
		CLS_SIMPLE   = 3'd0,
		CLS_FIXED    = 3'd1,
		CLS_PREFIX   = 3'd2,
		CLS_ANCHORED = 3'd3,
		CLS_BACKREF  = 3'd4
	} pat_class_t;

	typedef struct packed {
		logic at_first_byte;
		logic escape_pending;
		logic prev_raw_backslash;
		logic caret_seen;
		logic meta_seen;
		logic backref_seen;
	} pat_state_t;

	localparam pat_state_t PAT_STATE_RST = '{
		at_first_byte:      1'b1,
		escape_pending:     1'b0,
		prev_raw_backslash: 1'b0,
		caret_seen:         1'b0,
		meta_seen:          1'b0,
		backref_seen:       1'b0
	};

	typedef struct packed {
		logic       end_anchor;
		logic       begin_anchor;
		logic       saw_meta;
		pat_class_t pattern_class;
	} pat_result_t;

endpackage

@@ design/rpc_apb_regs.sv @@
module rpc_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpc_pkg::PADDR_W-1:0] paddr,
	input  logic [rpc_pkg::PDATA_W-1:0] pwdata,
	output logic [rpc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output logic                         extended_syntax
);
	import rpc_pkg::*;

	logic                     ext_q;
	logic                     wr_en;
	logic [PADDR_W-3:0]       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 1'b0;
		end else if (wr_en && reg_idx == REG_EXTENDED_SYNTAX) begin
			ext_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_EXTENDED_SYNTAX) begin
			prdata[0] = ext_q;
		end
	end

	assign extended_syntax = ext_q;

endmodule

@@ design/rpc_decode.sv @@
module rpc_decode (
	input  rpc_pkg::pat_state_t         st,
	input  logic [rpc_pkg::BYTE_W-1:0] pattern_byte,
	input  logic                        last_byte,
	input  logic                        no_byte,
	input  logic                        ere,
	output rpc_pkg::pat_state_t         st_next,
	output rpc_pkg::pat_result_t        res
);
	import rpc_pkg::*;

	logic is_ref;
	logic is_bre_esc_meta;
	logic is_plain_meta;
	logic eol;

	assign is_ref = (pattern_byte >= CH_ONE) && (pattern_byte <= CH_NINE);

	always_comb begin
		is_bre_esc_meta = pattern_byte inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
			CH_PIPE, CH_PLUS, CH_QUESTION};
		is_plain_meta = (pattern_byte inside {CH_DOT, CH_STAR, CH_LBRACKET}) ||
			(ere && is_bre_esc_meta);
	end

	assign eol = !no_byte && last_byte && pattern_byte == CH_DOLLAR &&
		!st.prev_raw_backslash;

	always_comb begin
		st_next = st;
		if (!no_byte) begin
			if (st.at_first_byte && pattern_byte == CH_CARET) begin
				st_next.caret_seen = 1'b1;
			end else if (st.escape_pending) begin
				if (is_ref) begin
					st_next.backref_seen = 1'b1;
				end else if (!ere && is_bre_esc_meta) begin
					st_next.meta_seen = 1'b1;
				end
				st_next.escape_pending = 1'b0;
			end else if (pattern_byte == CH_BACKSLASH && !last_byte) begin
				st_next.escape_pending = 1'b1;
			end else begin
				// A dollar sign anywhere but at the end counts as a metacharacter.
				if (is_plain_meta || (pattern_byte == CH_DOLLAR && !last_byte)) begin
					st_next.meta_seen = 1'b1;
				end
			end
			st_next.at_first_byte      = 1'b0;
			st_next.prev_raw_backslash = (pattern_byte == CH_BACKSLASH);
		end
	end

	always_comb begin
		if (st_next.backref_seen) begin
			res.pattern_class = CLS_BACKREF;
		end else if (st_next.meta_seen) begin
			res.pattern_class = CLS_SIMPLE;
		end else if (st_next.caret_seen && eol) begin
			res.pattern_class = CLS_ANCHORED;
		end else if (st_next.caret_seen) begin
			res.pattern_class = CLS_PREFIX;
		end else if (!eol) begin
			res.pattern_class = CLS_FIXED;
		end else begin
			res.pattern_class = CLS_SIMPLE;
		end
		res.saw_meta     = st_next.meta_seen;
		res.begin_anchor = st_next.caret_seen;
		res.end_anchor   = eol;
	end

endmodule

@@ design/regex_pattern_classifier_core.sv @@
// Regex pattern classifier core.
// A pattern arrives one byte per request on the s_axis channel: tdata carries
// the byte, tlast marks the final request of the pattern and tuser marks a
// request that carries no byte (used for an empty pattern, ignored mid-pattern).
// For each pattern exactly one result leaves on m_axis, produced by the request
// marked tlast: class, metacharacter flag and the begin and end anchor flags.
// The APB port holds one register, extended_syntax at address 0 (1 = ERE rules).
// It should only be written while no pattern is in flight.
// A request is captured in the input register and decoded from there; the
// result of a final request is loaded into the output register when that request
// is processed, and m_tvalid is driven from the output register.
// Throughput: one request per cycle while no final byte waits for the result
// slot, set by the flag update that every byte makes to the pattern state.
// When m_tready is low, the pending result is held; further non-final bytes
// are still taken, and a final byte waits in the input register, with s_tready
// low, until the result slot frees.
// Reset clears the pattern state, both valid flags and the register.
module regex_pattern_classifier_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpc_pkg::PADDR_W-1:0] paddr,
	input  logic [rpc_pkg::PDATA_W-1:0] pwdata,
	output logic [rpc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rpc_pkg::TDATA_W-1:0] s_tdata,  // [7:0] pattern_byte
	input  logic                         s_tlast,  // last_byte
	input  logic                         s_tuser,  // [0] no_byte
	// Result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [2:0] pattern_class, [3] saw_meta, [4] begin_anchor, [5] end_anchor, [7:6] zero
	output logic [rpc_pkg::TDATA_W-1:0] m_tdata
);
	import rpc_pkg::*;

	logic                  ext_syntax;
	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic                  last_s1;
	logic                  none_s1;
	logic                  proc;
	pat_state_t            st_q;
	pat_state_t            st_next;
	pat_result_t           res;
	pat_result_t           res_q;
	logic                  out_valid_q;

	rpc_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.extended_syntax (ext_syntax)
	);

	rpc_decode u_decode (
		.st           (st_q),
		.pattern_byte (byte_s1),
		.last_byte    (last_s1),
		.no_byte      (none_s1),
		.ere          (ext_syntax),
		.st_next      (st_next),
		.res          (res)
	);

	// Only a final byte needs room in the result register.
	assign proc     = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
			last_s1 <= s_tlast;
			none_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PAT_STATE_RST;
		end else if (proc) begin
			st_q <= last_s1 ? PAT_STATE_RST : st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W - $bits(pat_result_t)){1'b0}}, res_q};

	// A new result only appears after a final byte was decoded.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(proc && last_s1))
		else $error("result raised without a final byte");

	// The pattern state returns to its start after each final byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (st_q == PAT_STATE_RST))
		else $error("pattern state not cleared after final byte");

	// An escape can only be open once the first byte has gone by.
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.escape_pending |-> !st_q.at_first_byte)
		else $error("escape pending at first byte");

	// A stalled result is never overwritten by the next pattern.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(res_q)))
		else $error("pending result lost under stall");

endmodule

@@ test/tb.sv @@
module tb;
	import rpc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 205;
	localparam int REPORT_MAX = 10;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] SPECIAL_CH [17] = '{
		CH_CARET, CH_DOLLAR, CH_BACKSLASH, CH_DOT, CH_STAR, CH_LBRACKET, CH_PLUS,
		CH_QUESTION, CH_PIPE, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
		CH_ONE, CH_NINE, CH_ZERO, CH_BACKSLASH
	};

	typedef struct packed {
		logic [BYTE_W-1:0] pat_byte;
		logic              last;
		logic              none;
	} pat_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;  // [7:0] pattern_byte
	logic               s_tlast = 1'b0;  // last_byte
	logic               s_tuser = 1'b0;  // [0] no_byte
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// [2:0] pattern_class, [3] saw_meta, [4] begin_anchor, [5] end_anchor
	logic [TDATA_W-1:0] m_tdata;

	pat_req_t    byte_q[$];
	pat_result_t class_exp_q[$];
	pat_state_t  scan_st = PAT_STATE_RST;
	logic        ere_mode = 1'b0;
	logic        s_fire = 1'b0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          bytes_queued = 0;
	int          bytes_taken = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          cycle_cnt = 0;
	int          class_hits [5] = '{0, 0, 0, 0, 0};

	regex_pattern_classifier_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit is_plain_meta(logic [BYTE_W-1:0] b, logic ere);
		if (b inside {CH_DOT, CH_STAR, CH_LBRACKET})
			return 1'b1;
		return ere && (b inside {CH_PLUS, CH_QUESTION, CH_PIPE, CH_LBRACE, CH_RBRACE,
			CH_LPAREN, CH_RPAREN});
	endfunction

	// Updates the scan state with one accepted request and queues the class
	// expected when the request closes the pattern.
	function void scan_request(pat_req_t r);
		logic        eol;
		pat_result_t res;
		eol = 1'b0;
		if (!r.none) begin
			eol = r.last && r.pat_byte == CH_DOLLAR && !scan_st.prev_raw_backslash;
			if (scan_st.at_first_byte && r.pat_byte == CH_CARET) begin
				scan_st.caret_seen = 1'b1;
			end else if (scan_st.escape_pending) begin
				if (r.pat_byte >= CH_ONE && r.pat_byte <= CH_NINE)
					scan_st.backref_seen = 1'b1;
				else if (!ere_mode && (r.pat_byte inside {CH_LPAREN, CH_RPAREN, CH_LBRACE,
					CH_RBRACE, CH_PIPE, CH_PLUS, CH_QUESTION}))
					scan_st.meta_seen = 1'b1;
				scan_st.escape_pending = 1'b0;
			end else if (r.pat_byte == CH_BACKSLASH && !r.last) begin
				scan_st.escape_pending = 1'b1;
			end else if (is_plain_meta(r.pat_byte, ere_mode) ||
				(r.pat_byte == CH_DOLLAR && !r.last)) begin
				scan_st.meta_seen = 1'b1;
			end
			scan_st.at_first_byte = 1'b0;
			scan_st.prev_raw_backslash = (r.pat_byte == CH_BACKSLASH);
		end
		if (r.last) begin
			if (scan_st.backref_seen)
				res.pattern_class = CLS_BACKREF;
			else if (scan_st.meta_seen)
				res.pattern_class = CLS_SIMPLE;
			else if (scan_st.caret_seen)
				res.pattern_class = eol ? CLS_ANCHORED : CLS_PREFIX;
			else
				res.pattern_class = eol ? CLS_SIMPLE : CLS_FIXED;
			res.saw_meta = scan_st.meta_seen;
			res.begin_anchor = scan_st.caret_seen;
			res.end_anchor = eol;
			class_exp_q.push_back(res);
			scan_st = PAT_STATE_RST;
		end
	endfunction

	function void note_mismatch(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0d: %s expected %0d, got %0d", cycle_cnt, what, want, got);
	endfunction

	// Sender and receiver, both changing on the falling edge.
	always @(negedge clk) begin
		pat_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || s_fire) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = byte_q.pop_front();
					s_tdata <= nxt.pat_byte;
					s_tlast <= nxt.last;
					s_tuser <= nxt.none;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Both handshakes are sampled on the rising edge.
	always @(posedge clk) begin
		pat_req_t    taken;
		pat_result_t want;
		pat_result_t got;
		s_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				taken.pat_byte = s_tdata;
				taken.last = s_tlast;
				taken.none = s_tuser;
				bytes_taken++;
				scan_request(taken);
			end
			if (m_tvalid && m_tready) begin
				got = pat_result_t'(m_tdata[5:0]);
				results_seen++;
				if (m_tdata[2:0] < 3'd5)
					class_hits[m_tdata[2:0]]++;
				if (class_exp_q.size() == 0) begin
					note_mismatch("unexpected result, tdata", 0, m_tdata);
				end else begin
					want = class_exp_q.pop_front();
					if (got.pattern_class != want.pattern_class)
						note_mismatch("pattern_class", want.pattern_class, got.pattern_class);
					if (got.saw_meta != want.saw_meta)
						note_mismatch("saw_meta", want.saw_meta, got.saw_meta);
					if (got.begin_anchor != want.begin_anchor)
						note_mismatch("begin_anchor", want.begin_anchor, got.begin_anchor);
					if (got.end_anchor != want.end_anchor)
						note_mismatch("end_anchor", want.end_anchor, got.end_anchor);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_req(logic [BYTE_W-1:0] b, logic last, logic none);
		pat_req_t r;
		r.pat_byte = b;
		r.last = last;
		r.none = none;
		byte_q.push_back(r);
		bytes_queued++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_req(s[i], i == s.len() - 1, 1'b0);
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		if ($urandom_range(99) < 65)
			return SPECIAL_CH[$urandom_range(16)];
		return BYTE_W'($urandom_range(255));
	endfunction

	// Builds one random pattern. Most are literal bodies with optional anchors
	// and escape pairs, so the fixed, prefix and anchored classes come up often.
	task automatic push_random_pattern();
		logic [BYTE_W-1:0] body[$];
		int                kind;
		int                len;
		bit                close_empty;
		kind = $urandom_range(99);
		if (kind < 4) begin
			push_req(BYTE_W'($urandom_range(255)), 1'b1, 1'b1);
			return;
		end
		len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
		if (kind < 55) begin
			if ($urandom_range(1))
				body.push_back(CH_CARET);
			while (body.size() < len) begin
				case ($urandom_range(6))
					0, 1, 2: body.push_back(CH_LOWER_A + BYTE_W'($urandom_range(25)));
					3: body.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
					4: begin
						body.push_back(CH_BACKSLASH);
						body.push_back(pick_byte());
					end
					5: body.push_back(CH_CARET);
					default: body.push_back(BYTE_W'($urandom_range(255)));
				endcase
			end
			if ($urandom_range(1)) begin
				if ($urandom_range(3) == 0)
					body.push_back(CH_BACKSLASH);
				body.push_back(CH_DOLLAR);
			end
		end else begin
			repeat (len) body.push_back(pick_byte());
		end
		close_empty = ($urandom_range(99) < 6);
		foreach (body[i]) begin
			if ($urandom_range(99) < 6)
				push_req(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
			push_req(body[i], !close_empty && i == body.size() - 1, 1'b0);
		end
		if (close_empty)
			push_req(BYTE_W'($urandom_range(255)), 1'b1, 1'b1);
	endtask

	// Waits until every request has been taken and every class has come back,
	// then lets the pipeline settle before anything else happens.
	task automatic wait_drained();
		do @(negedge clk);
		while (bytes_taken != bytes_queued || class_exp_q.size() != 0 || byte_q.size() != 0);
		repeat (4) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_syntax(logic ere);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_EXTENDED_SYNTAX, 2'b00};
		pwdata <= {{(PDATA_W-1){1'b0}}, ere};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ere_mode = ere;
		@(posedge clk);
	endtask

	task automatic run_phase(logic ere, int idle, int stall, bit pause_mid);
		int goal;
		write_syntax(ere);
		idle_pct = idle;
		stall_pct = stall;
		goal = bytes_queued + RANDOM_PER_PHASE;
		while (bytes_queued < goal) begin
			push_random_pattern();
			// New patterns are held off here until every queued request is taken and every result is back.
			if (pause_mid && bytes_queued >= goal - RANDOM_PER_PHASE / 2) begin
				wait_drained();
				pause_mid = 1'b0;
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed patterns under the basic rules.
		write_syntax(1'b0);
		push_req(8'hFF, 1'b1, 1'b1);
		push_text("^a$");
		push_text("^");
		push_req(8'h00, 1'b0, 1'b0);
		push_req(CH_DOLLAR, 1'b1, 1'b0);
		push_req(8'hFF, 1'b1, 1'b0);
		push_text("\\9");
		push_text(".");
		push_text("\\$");
		push_text("\\");
		push_req(CH_LOWER_A, 1'b0, 1'b0);
		push_req(8'h00, 1'b0, 1'b1);
		push_req(CH_CARET, 1'b0, 1'b0);
		push_req(8'hA5, 1'b1, 1'b1);
		push_text("$$");
		push_text("a\\+");
		wait_drained();

		// Escapes and plain metacharacters read differently under the extended rules.
		write_syntax(1'b1);
		push_text("\\(");
		push_text("a+");
		wait_drained();

		run_phase(1'b0, 0, 0, 1'b0);
		run_phase(1'b1, 0, 0, 1'b1);
		run_phase(1'b0, 84, 0, 1'b0);
		run_phase(1'b1, 0, 84, 1'b0);
		run_phase(1'b0, 18, 18, 1'b1);
		run_phase(1'b1, 18, 18, 1'b0);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests forming %0d patterns under basic and extended rules,",
			bytes_taken, results_seen);
		$display("classes simple/fixed/prefix/anchored/backref: %0d/%0d/%0d/%0d/%0d",
			class_hits[0], class_hits[1], class_hits[2], class_hits[3], class_hits[4]);
		if (mismatches == 0 && class_exp_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d classes outstanding", mismatches, class_exp_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
